// File: rtl/assert_macros.svh
// Assertion macros used by the checker of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLKD(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// File: rtl/i2cseq_pkg.sv
// Types and constants of the I2C EEPROM transfer sequencer.
// No dependencies; used by the top level and its checker.
package i2cseq_pkg;

    // PAGE_BYTES must be a power of two.
    localparam int unsigned MEM_BYTES  = 32768;
    localparam int unsigned PAGE_BYTES = 64;
    localparam int unsigned PAGE_BITS  = $clog2(PAGE_BYTES);

    localparam logic [16:0] PTR_LIMIT = 17'(MEM_BYTES);
    localparam logic [16:0] PTR_LAST  = 17'(MEM_BYTES - 1);

    localparam logic [1:0] ACT_SEEK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_REPLY = 2'd3;

    localparam logic [2:0] OP_START_SEND   = 3'd0;
    localparam logic [2:0] OP_SEND         = 3'd1;
    localparam logic [2:0] OP_SEND_STOP    = 3'd2;
    localparam logic [2:0] OP_RESTART_SEND = 3'd3;
    localparam logic [2:0] OP_RECV_ACK     = 3'd4;
    localparam logic [2:0] OP_RECV_NACK    = 3'd5;

    localparam logic [2:0] ST_WRITTEN   = 3'd0;
    localparam logic [2:0] ST_READ_DATA = 3'd1;
    localparam logic [2:0] ST_SEEK_DONE = 3'd2;
    localparam logic [2:0] ST_BUS_ERROR = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;
    localparam logic [2:0] ST_DENIED    = 3'd5;

    localparam logic [1:0] MODE_READ_ONLY  = 2'd0;
    localparam logic [1:0] MODE_WRITE_ONLY = 2'd1;

    localparam logic [1:0] REG_OPEN_MODE   = 2'd0;
    localparam logic [1:0] REG_NONBLOCKING = 2'd1;
    localparam logic [1:0] REG_CONTROL     = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] offset;
        logic [7:0]  data_byte;
        logic        first_of_transfer;
        logic        last_of_transfer;
        logic        reply_acked;
        logic [7:0]  reply_byte;
    } in_item_t;

    typedef struct packed {
        logic        to_host;
        logic [2:0]  bus_op;
        logic [7:0]  bus_byte;
        logic [2:0]  host_status;
        logic [7:0]  host_byte;
        logic [15:0] pointer_now;
    } out_item_t;

endpackage

// File: rtl/i2c_eeprom_transfer_sequencer.sv
// Top level of the I2C EEPROM transfer sequencer: input register, sequencing
// logic and result register. Depends on i2cseq_pkg.
//
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_data (in_item_t)
// m_        out        m_valid / m_ready   m_data (out_item_t)
// cfg_      in         cfg_wr_en           cfg_addr, cfg_wr_data
//
// One transfer is accepted per cycle unless m_ready stalls the output; its
// result passes through the input register, then the result register. The
// rate is set by the state update between the two registers. Reset is
// synchronous, restores all state, empties both registers, holds s_ready low.
// A stall on m_ready backs up through the input register to s_ready.
module i2c_eeprom_transfer_sequencer
    import i2cseq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_CTRL, PH_HI, PH_LO, PH_RCTRL, PH_DATA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] mem_pointer_reg, mem_pointer_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_last_reg, held_last_next;
    logic        read_kind_reg, read_kind_next;
    logic        busy_reg, busy_next;

    logic [1:0]  open_mode_reg;
    logic        nonblocking_reg;
    logic [7:0]  control_reg;

    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    logic        advance;
    logic        res_valid;
    out_item_t   res;

    function automatic out_item_t bus_cmd(logic [2:0] op, logic [7:0] b);
        out_item_t o;
        o = '0;
        o.bus_op = op;
        o.bus_byte = b;
        return o;
    endfunction

    function automatic out_item_t host_resp(logic [2:0] st, logic [7:0] b);
        out_item_t o;
        o = '0;
        o.to_host = 1'b1;
        o.host_status = st;
        o.host_byte = b;
        return o;
    endfunction

    function automatic out_item_t data_cmd(logic rd, logic lst, logic [7:0] b,
                                           logic [15:0] p);
        logic fin;
        if (rd) begin
            fin = lst || ({1'b0, p} == PTR_LAST);
            return bus_cmd(fin ? OP_RECV_NACK : OP_RECV_ACK, 8'd0);
        end
        fin = lst || (p[PAGE_BITS-1:0] == {PAGE_BITS{1'b1}});
        return bus_cmd(fin ? OP_SEND_STOP : OP_SEND, b);
    endfunction

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = aresetn && (!in_valid_reg || advance);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        logic is_read;
        logic denied;
        phase_next       = phase_reg;
        mem_pointer_next = mem_pointer_reg;
        held_byte_next   = held_byte_reg;
        held_last_next   = held_last_reg;
        read_kind_next   = read_kind_reg;
        busy_next        = busy_reg;
        res_valid        = 1'b0;
        res              = '0;
        is_read          = (in_data_reg.action == ACT_READ);
        denied = is_read ? (open_mode_reg == MODE_WRITE_ONLY)
                         : (open_mode_reg == MODE_READ_ONLY);
        case (in_data_reg.action)
            ACT_SEEK: begin
                res_valid = 1'b1;
                if (busy_reg || phase_reg != PH_IDLE) begin
                    res = host_resp(ST_BUSY, 8'd0);
                end else begin
                    mem_pointer_next = in_data_reg.offset;
                    res = host_resp(ST_SEEK_DONE, 8'd0);
                end
            end
            ACT_WRITE, ACT_READ: begin
                res_valid = 1'b1;
                if (phase_reg != PH_IDLE) begin
                    res = host_resp(ST_BUSY, 8'd0);
                end else if (denied) begin
                    res = host_resp(ST_DENIED, 8'd0);
                end else if ({1'b0, mem_pointer_reg} >= PTR_LIMIT) begin
                    busy_next = 1'b0;
                    res = host_resp(ST_DENIED, 8'd0);
                end else begin
                    busy_next      = 1'b1;
                    read_kind_next = is_read;
                    held_byte_next = is_read ? 8'd0 : in_data_reg.data_byte;
                    held_last_next = in_data_reg.last_of_transfer;
                    if (in_data_reg.first_of_transfer ||
                        (!is_read && mem_pointer_reg[PAGE_BITS-1:0] == '0)) begin
                        phase_next = PH_CTRL;
                        res = bus_cmd(OP_START_SEND, control_reg);
                    end else begin
                        phase_next = PH_DATA;
                        res = data_cmd(is_read, in_data_reg.last_of_transfer,
                                       in_data_reg.data_byte, mem_pointer_reg);
                    end
                end
            end
            default: begin
                res_valid = (phase_reg != PH_IDLE);
                if (!in_data_reg.reply_acked && phase_reg != PH_IDLE) begin
                    if ((phase_reg == PH_CTRL || phase_reg == PH_HI) &&
                        !nonblocking_reg) begin
                        phase_next = PH_CTRL;
                        res = bus_cmd(OP_START_SEND, control_reg);
                    end else begin
                        phase_next = PH_IDLE;
                        busy_next  = 1'b0;
                        res = host_resp(ST_BUS_ERROR, 8'd0);
                    end
                end else begin
                    case (phase_reg)
                        PH_CTRL: begin
                            phase_next = PH_HI;
                            res = bus_cmd(OP_SEND, mem_pointer_reg[15:8]);
                        end
                        PH_HI: begin
                            phase_next = PH_LO;
                            res = bus_cmd(OP_SEND, mem_pointer_reg[7:0]);
                        end
                        PH_LO: begin
                            if (read_kind_reg) begin
                                phase_next = PH_RCTRL;
                                res = bus_cmd(OP_RESTART_SEND, control_reg | 8'h01);
                            end else begin
                                phase_next = PH_DATA;
                                res = data_cmd(read_kind_reg, held_last_reg,
                                               held_byte_reg, mem_pointer_reg);
                            end
                        end
                        PH_RCTRL: begin
                            phase_next = PH_DATA;
                            res = data_cmd(read_kind_reg, held_last_reg,
                                           held_byte_reg, mem_pointer_reg);
                        end
                        PH_DATA: begin
                            phase_next       = PH_IDLE;
                            mem_pointer_next = mem_pointer_reg + 16'd1;
                            if (held_last_reg) begin
                                busy_next = 1'b0;
                            end
                            res = read_kind_reg
                                ? host_resp(ST_READ_DATA, in_data_reg.reply_byte)
                                : host_resp(ST_WRITTEN, 8'd0);
                        end
                        default: begin
                            res = '0;
                        end
                    endcase
                end
            end
        endcase
        res.pointer_now = mem_pointer_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_mode_reg   <= 2'd2;
            nonblocking_reg <= 1'b0;
            control_reg     <= 8'd160;
            phase_reg       <= PH_IDLE;
            mem_pointer_reg <= '0;
            held_byte_reg   <= '0;
            held_last_reg   <= 1'b0;
            read_kind_reg   <= 1'b0;
            busy_reg        <= 1'b0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_OPEN_MODE:   open_mode_reg   <= cfg_wr_data[1:0];
                    REG_NONBLOCKING: nonblocking_reg <= cfg_wr_data[0];
                    REG_CONTROL:     control_reg     <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                phase_reg       <= phase_next;
                mem_pointer_reg <= mem_pointer_next;
                held_byte_reg   <= held_byte_next;
                held_last_reg   <= held_last_next;
                read_kind_reg   <= read_kind_next;
                busy_reg        <= busy_next;
            end
            if (advance && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

endmodule

// File: rtl/i2cseq_checker.sv
// Port-level checker for the I2C EEPROM transfer sequencer, bound to the top.
// Depends on i2cseq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cseq_checker
    import i2cseq_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `ASSERT_CLKD(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_valid)
    `ASSERT_CLKD(a_host_clean, aclk, aresetn, m_valid && m_data.to_host |-> m_data.bus_op == OP_START_SEND && m_data.bus_byte == 8'd0 && m_data.host_status <= ST_DENIED)
    `ASSERT_CLKD(a_bus_clean, aclk, aresetn, m_valid && !m_data.to_host |-> m_data.host_status == ST_WRITTEN && m_data.host_byte == 8'd0 && m_data.bus_op <= OP_RECV_NACK)

endmodule

bind i2c_eeprom_transfer_sequencer i2cseq_checker u_checker (.*);

// File: verif/i2c_eeprom_transfer_sequencer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the I2C EEPROM transfer sequencer: a directed table, then
// random request and bus-reply traffic under several register settings, all scored.
// Depends on i2cseq_pkg and the top level i2c_eeprom_transfer_sequencer.
module i2c_eeprom_transfer_sequencer_test
    import i2cseq_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 110;
    localparam int unsigned PRINT_LIMIT   = 200;

    localparam logic [1:0] MODE_READ_WRITE = 2'd2;
    localparam logic [1:0] MODE_UNLISTED   = 2'd3;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_CTRL,
        SEQ_ADDR_HI,
        SEQ_ADDR_LO,
        SEQ_READ_CTRL,
        SEQ_DATA
    } seq_phase_e;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } table_row_t;

    localparam out_item_t NO_RESULT = '0;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_item_t   s_data      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_item_t  m_data;
    logic       cfg_wr_en   = 1'b0;
    logic [1:0] cfg_addr    = REG_OPEN_MODE;
    logic [7:0] cfg_wr_data = 8'h00;

    logic [1:0]  open_mode_r    = MODE_READ_WRITE;
    logic        nonblocking_r  = 1'b0;
    logic [7:0]  control_byte_r = 8'hA0;
    seq_phase_e  seq_phase      = SEQ_IDLE;
    logic [15:0] mem_ptr        = 16'h0000;
    logic [7:0]  held_byte      = 8'h00;
    logic        held_last      = 1'b0;
    logic        read_kind      = 1'b0;
    logic        busy           = 1'b0;

    out_item_t   due_results[$];
    table_row_t  directed_rows[$];
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    int unsigned burst_left = 0;
    int unsigned ready_left = 0;

    i2c_eeprom_transfer_sequencer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic out_item_t bus_word(logic [2:0] op, logic [7:0] b, logic [15:0] ptr);
        out_item_t r;
        r             = '0;
        r.bus_op      = op;
        r.bus_byte    = b;
        r.pointer_now = ptr;
        return r;
    endfunction

    function automatic out_item_t host_word(logic [2:0] st, logic [7:0] b, logic [15:0] ptr);
        out_item_t r;
        r             = '0;
        r.to_host     = 1'b1;
        r.host_status = st;
        r.host_byte   = b;
        r.pointer_now = ptr;
        return r;
    endfunction

    // Flags are first of transfer, last of transfer and reply acknowledged, in that order.
    function automatic table_row_t entry(logic [1:0] act, logic [15:0] ofs, logic [7:0] dat,
                                         logic [2:0] flags, logic [7:0] rb, bit typed,
                                         out_item_t res);
        table_row_t r;
        r.item   = '{act, ofs, dat, flags[2], flags[1], flags[0], rb};
        r.typed  = typed;
        r.result = res;
        return r;
    endfunction

    function automatic out_item_t abort_transfer();
        seq_phase = SEQ_IDLE;
        busy      = 1'b0;
        return host_word(ST_BUS_ERROR, 8'h00, mem_ptr);
    endfunction

    function automatic out_item_t open_addressing();
        seq_phase = SEQ_CTRL;
        return bus_word(OP_START_SEND, control_byte_r, mem_ptr);
    endfunction

    function automatic out_item_t data_command();
        logic fin;
        seq_phase = SEQ_DATA;
        if (read_kind) begin
            fin = held_last || (32'(mem_ptr) == MEM_BYTES - 1);
            return bus_word(fin ? OP_RECV_NACK : OP_RECV_ACK, 8'h00, mem_ptr);
        end
        fin = held_last || (32'(mem_ptr) % PAGE_BYTES == PAGE_BYTES - 1);
        return bus_word(fin ? OP_SEND_STOP : OP_SEND, held_byte, mem_ptr);
    endfunction

    function automatic bit advance_sequencer(input in_item_t req, output out_item_t res);
        logic is_read;
        res     = '0;
        is_read = (req.action == ACT_READ);
        case (req.action)
            ACT_SEEK: begin
                if (busy || seq_phase != SEQ_IDLE) begin
                    res = host_word(ST_BUSY, 8'h00, mem_ptr);
                end else begin
                    mem_ptr = req.offset;
                    res     = host_word(ST_SEEK_DONE, 8'h00, mem_ptr);
                end
                return 1'b1;
            end
            ACT_WRITE, ACT_READ: begin
                if (seq_phase != SEQ_IDLE) begin
                    res = host_word(ST_BUSY, 8'h00, mem_ptr);
                end else if (is_read ? (open_mode_r == MODE_WRITE_ONLY)
                                     : (open_mode_r == MODE_READ_ONLY)) begin
                    res = host_word(ST_DENIED, 8'h00, mem_ptr);
                end else if (32'(mem_ptr) >= MEM_BYTES) begin
                    busy = 1'b0;
                    res  = host_word(ST_DENIED, 8'h00, mem_ptr);
                end else begin
                    busy      = 1'b1;
                    read_kind = is_read;
                    held_byte = is_read ? 8'h00 : req.data_byte;
                    held_last = req.last_of_transfer;
                    if (req.first_of_transfer || (!is_read && 32'(mem_ptr) % PAGE_BYTES == 0))
                        res = open_addressing();
                    else
                        res = data_command();
                end
                return 1'b1;
            end
            default: ;
        endcase
        case (seq_phase)
            SEQ_CTRL, SEQ_ADDR_HI: begin
                if (!req.reply_acked) begin
                    if (nonblocking_r)
                        res = abort_transfer();
                    else
                        res = open_addressing();
                end else if (seq_phase == SEQ_CTRL) begin
                    seq_phase = SEQ_ADDR_HI;
                    res       = bus_word(OP_SEND, mem_ptr[15:8], mem_ptr);
                end else begin
                    seq_phase = SEQ_ADDR_LO;
                    res       = bus_word(OP_SEND, mem_ptr[7:0], mem_ptr);
                end
            end
            SEQ_ADDR_LO: begin
                if (!req.reply_acked) begin
                    res = abort_transfer();
                end else if (read_kind) begin
                    seq_phase = SEQ_READ_CTRL;
                    res       = bus_word(OP_RESTART_SEND, control_byte_r | 8'h01, mem_ptr);
                end else begin
                    res = data_command();
                end
            end
            SEQ_READ_CTRL: begin
                if (!req.reply_acked)
                    res = abort_transfer();
                else
                    res = data_command();
            end
            SEQ_DATA: begin
                if (!req.reply_acked) begin
                    res = abort_transfer();
                end else begin
                    seq_phase = SEQ_IDLE;
                    mem_ptr   = mem_ptr + 16'd1;
                    if (held_last)
                        busy = 1'b0;
                    if (read_kind)
                        res = host_word(ST_READ_DATA, req.reply_byte, mem_ptr);
                    else
                        res = host_word(ST_WRITTEN, 8'h00, mem_ptr);
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic in_item_t next_request();
        in_item_t    it;
        int unsigned pick;
        logic        want_read;
        it.action            = ACT_REPLY;
        it.offset            = 16'($urandom);
        it.data_byte         = 8'($urandom);
        it.first_of_transfer = 1'($urandom);
        it.last_of_transfer  = 1'($urandom);
        it.reply_acked       = 1'($urandom);
        it.reply_byte        = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (open_mode_r == MODE_READ_ONLY)
            want_read = 1'b1;
        else if (open_mode_r == MODE_WRITE_ONLY)
            want_read = 1'b0;
        else
            want_read = 1'($urandom);
        if ($urandom_range(0, 6) == 0)
            want_read = ~want_read;
        if (seq_phase != SEQ_IDLE) begin
            if (pick < 90) begin
                it.action      = ACT_REPLY;
                it.reply_acked = ($urandom_range(0, 9) != 0);
            end else if (pick < 95) begin
                it.action = ACT_SEEK;
            end else begin
                it.action = want_read ? ACT_READ : ACT_WRITE;
            end
        end else if (busy) begin
            if (pick < 80) begin
                it.action            = read_kind ? ACT_READ : ACT_WRITE;
                it.first_of_transfer = ($urandom_range(0, 7) == 0);
                it.last_of_transfer  = ($urandom_range(0, 5) == 0);
            end else if (pick < 90) begin
                it.action = ACT_SEEK;
            end else if (pick < 95) begin
                it.action = ACT_REPLY;
            end else begin
                it.action = want_read ? ACT_READ : ACT_WRITE;
            end
        end else if (pick < 30) begin
            it.action = ACT_SEEK;
            case ($urandom_range(0, 5))
                0, 1: it.offset = 16'($urandom_range(0, MEM_BYTES - 1));
                2: it.offset = 16'($urandom_range(0, MEM_BYTES / PAGE_BYTES - 1) * PAGE_BYTES
                                   + $urandom_range(PAGE_BYTES - 4, PAGE_BYTES - 1));
                3: it.offset = 16'(MEM_BYTES - $urandom_range(1, 4));
                4: it.offset = 16'($urandom_range(MEM_BYTES, 65535));
                default: ;
            endcase
        end else if (pick < 95) begin
            it.action            = want_read ? ACT_READ : ACT_WRITE;
            it.first_of_transfer = ($urandom_range(0, 9) != 0);
            it.last_of_transfer  = ($urandom_range(0, 3) == 0);
        end
        return it;
    endfunction

    task automatic issue(input in_item_t item, input bit typed, input out_item_t typed_result);
        out_item_t   predicted;
        bit          produced;
        int unsigned gap;
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        produced = advance_sequencer(item, predicted);
        if (produced)
            due_results.push_back(typed ? typed_result : predicted);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [1:0] mode, input logic nb, input logic [7:0] ctrl);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_OPEN_MODE;
        cfg_wr_data <= {6'b0, mode};
        @(posedge aclk);
        cfg_addr    <= REG_NONBLOCKING;
        cfg_wr_data <= {7'b0, nb};
        @(posedge aclk);
        cfg_addr    <= REG_CONTROL;
        cfg_wr_data <= ctrl;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        open_mode_r    = mode;
        nonblocking_r  = nb;
        control_byte_r = ctrl;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] seen,
                                   input logic [15:0] wanted);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch in %s: got %0h, expected %0h, cycle %0d",
                     what, seen, wanted, cycles);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [15:0] seen,
                               input logic [15:0] wanted);
        if (seen !== wanted)
            report_mismatch(what, seen, wanted);
    endtask

    always @(posedge aclk) begin
        if (ready_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    m_ready    <= 1'b0;
                    ready_left = $urandom_range(1, 6);
                end
                1: begin
                    m_ready    <= 1'b1;
                    ready_left = $urandom_range(40, 200);
                end
                default: begin
                    m_ready    <= 1'b1;
                    ready_left = $urandom_range(1, 10);
                end
            endcase
        end else begin
            ready_left--;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected transfer, pointer", m_data.pointer_now, 16'h0);
            end else begin
                want = due_results.pop_front();
                check_field("to_host", 16'(m_data.to_host), 16'(want.to_host));
                check_field("bus_op", 16'(m_data.bus_op), 16'(want.bus_op));
                check_field("bus_byte", 16'(m_data.bus_byte), 16'(want.bus_byte));
                check_field("host_status", 16'(m_data.host_status), 16'(want.host_status));
                check_field("host_byte", 16'(m_data.host_byte), 16'(want.host_byte));
                check_field("pointer_now", m_data.pointer_now, want.pointer_now);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        directed_rows = '{
            entry(ACT_REPLY, 16'h1234, 8'h55, 3'b111, 8'hAA, 1'b0, NO_RESULT),
            entry(ACT_SEEK, 16'hFFFF, 8'h00, 3'b000, 8'h00, 1'b1,
                  host_word(ST_SEEK_DONE, 8'h00, 16'hFFFF)),
            entry(ACT_WRITE, 16'h0000, 8'hFF, 3'b111, 8'hFF, 1'b1,
                  host_word(ST_DENIED, 8'h00, 16'hFFFF)),
            entry(ACT_READ, 16'h0000, 8'h00, 3'b110, 8'h00, 1'b1,
                  host_word(ST_DENIED, 8'h00, 16'hFFFF)),
            entry(ACT_SEEK, 16'h7FFF, 8'h00, 3'b000, 8'h00, 1'b1,
                  host_word(ST_SEEK_DONE, 8'h00, 16'h7FFF)),
            entry(ACT_READ, 16'h0000, 8'h00, 3'b100, 8'h00, 1'b1,
                  bus_word(OP_START_SEND, 8'hA0, 16'h7FFF)),
            entry(ACT_SEEK, 16'h0000, 8'h00, 3'b000, 8'h00, 1'b1,
                  host_word(ST_BUSY, 8'h00, 16'h7FFF)),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b001, 8'h00, 1'b1,
                  bus_word(OP_SEND, 8'h7F, 16'h7FFF)),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b001, 8'h00, 1'b1,
                  bus_word(OP_SEND, 8'hFF, 16'h7FFF)),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b001, 8'h00, 1'b1,
                  bus_word(OP_RESTART_SEND, 8'hA1, 16'h7FFF)),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b001, 8'h00, 1'b1,
                  bus_word(OP_RECV_NACK, 8'h00, 16'h7FFF)),
            entry(ACT_WRITE, 16'hFFFF, 8'hFF, 3'b111, 8'hFF, 1'b1,
                  host_word(ST_BUSY, 8'h00, 16'h7FFF)),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b001, 8'hFF, 1'b1,
                  host_word(ST_READ_DATA, 8'hFF, 16'h8000)),
            entry(ACT_SEEK, 16'h0000, 8'h00, 3'b000, 8'h00, 1'b1,
                  host_word(ST_BUSY, 8'h00, 16'h8000)),
            entry(ACT_READ, 16'h0000, 8'h00, 3'b000, 8'h00, 1'b1,
                  host_word(ST_DENIED, 8'h00, 16'h8000)),
            entry(ACT_SEEK, 16'h003F, 8'h00, 3'b000, 8'h00, 1'b1,
                  host_word(ST_SEEK_DONE, 8'h00, 16'h003F)),
            entry(ACT_WRITE, 16'h0000, 8'h00, 3'b000, 8'h00, 1'b0, NO_RESULT),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b000, 8'h00, 1'b1,
                  host_word(ST_BUS_ERROR, 8'h00, 16'h003F)),
            entry(ACT_WRITE, 16'h0000, 8'hFF, 3'b110, 8'h00, 1'b0, NO_RESULT),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b000, 8'h00, 1'b0, NO_RESULT),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b001, 8'h00, 1'b0, NO_RESULT),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b001, 8'h00, 1'b0, NO_RESULT),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b001, 8'h00, 1'b0, NO_RESULT),
            entry(ACT_REPLY, 16'h0000, 8'h00, 3'b001, 8'h00, 1'b1,
                  host_word(ST_WRITTEN, 8'h00, 16'h0040))
        };
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i])
            issue(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph)
                0: apply_settings(MODE_READ_ONLY, 1'b0, 8'h00);
                1: apply_settings(MODE_WRITE_ONLY, 1'b1, 8'hFE);
                2: apply_settings(MODE_UNLISTED, 1'b1, 8'hFF);
                3: apply_settings(MODE_READ_WRITE, 1'b0, 8'hA0);
                4: apply_settings(MODE_READ_WRITE, 1'b1, 8'h50);
                default: apply_settings(2'($urandom_range(0, 3)), 1'($urandom),
                                        8'($urandom));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue(next_request(), 1'b0, NO_RESULT);
        end
        drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/i2cseq_pkg.sv
rtl/i2c_eeprom_transfer_sequencer.sv
rtl/i2cseq_checker.sv
verif/i2c_eeprom_transfer_sequencer_test.sv
